[src/priority_round_robin_scheduler_macros.svh]
// assertion macros for the scheduler checker
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_MACROS_SVH

// same-cycle implication, checked outside reset
`define PRRS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prrs check failed");

// next-cycle implication, checked outside reset
`define PRRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prrs check failed");

// next-cycle implication that also holds through reset
`define PRRS_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("prrs check failed");

`endif

[src/prrs_pkg.sv]
// ----------------------------------------------------------------------------
// prrs_pkg
// shared types and constants of the priority round-robin scheduler
// ----------------------------------------------------------------------------
package prrs_pkg;

  localparam int MAX_THREADS = 16;
  localparam int IDX_W       = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SCHED_ENABLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_QUANTUM = 8'd1;

  localparam logic [15:0] DEFAULT_QUANTUM = 16'd100;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_TICK = 1'b1
  } req_kind_t;

  // input tdata layout, lowest bits last in the list
  typedef struct packed {
    logic [31:0] now_ticks;
    logic [7:0]  thread_priority;
    logic [7:0]  thread_id;
  } in_data_t;

  localparam int S_DATA_W = $bits(in_data_t);

  typedef struct packed {
    req_kind_t   kind;
    logic [7:0]  thread_id;
    logic [7:0]  thread_priority;
    logic [31:0] now_ticks;
  } req_t;

  // output tdata layout, padded to two bytes
  typedef struct packed {
    logic [4:0] pad;
    logic       table_full;
    logic       switched;
    logic       current_valid;
    logic [7:0] current_id;
  } out_data_t;

  localparam int M_DATA_W = $bits(out_data_t);

  typedef struct packed {
    logic [7:0] prio;
    logic [7:0] id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // cyclic successor of a table index
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(idx) + CNT_W'(1);
    return (inc >= cnt) ? '0 : inc[IDX_W-1:0];
  endfunction

endpackage

[src/prrs_ram.sv]
// ----------------------------------------------------------------------------
// prrs_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module prrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/prrs_front.sv]
// ----------------------------------------------------------------------------
// prrs_front
// accepts request transactions, decodes them and queues them for the back end
// ----------------------------------------------------------------------------
module prrs_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [prrs_pkg::S_DATA_W-1:0]   s_axis_tdata,
  input  logic [0:0]                      s_axis_tuser,
  output logic                            q_valid,
  output prrs_pkg::req_t                  q_req,
  input  logic                            q_pop
);
  import prrs_pkg::*;

  req_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;
  logic               push;
  logic               pop;
  in_data_t           din;
  req_t               dec;

  assign s_axis_tready = (fill < QCNT_W'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (fill != '0);
  assign pop           = q_pop && q_valid;
  assign q_req         = slots[rd_ptr];

  // classify the transaction
  always_comb begin
    din                 = in_data_t'(s_axis_tdata);
    dec.kind            = req_kind_t'(s_axis_tuser[0]);
    dec.thread_id       = din.thread_id;
    dec.thread_priority = din.thread_priority;
    dec.now_ticks       = din.now_ticks;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

[src/prrs_back.sv]
// ----------------------------------------------------------------------------
// prrs_back
// thread table, scheduling decision, table walk and result register
// ----------------------------------------------------------------------------
module prrs_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  prrs_pkg::req_t                    q_req,
  output logic                              q_pop,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [prrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prrs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [prrs_pkg::M_DATA_W-1:0]     m_axis_tdata
);
  import prrs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t           state;
  logic             sched_enable;
  logic [15:0]      time_quantum;
  logic [CNT_W-1:0] entry_count;
  logic [IDX_W-1:0] current_index;
  logic [IDX_W-1:0] walk_index;
  logic [7:0]       cur_id;
  logic [7:0]       cur_prio;
  logic [7:0]       max_prio;
  logic [31:0]      resume_time;
  logic [31:0]      walk_now;
  out_data_t        res;

  logic             ram_we;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic [ENTRY_W-1:0] ram_rbits;
  logic [31:0]      elapsed;
  logic             consider;
  logic             is_full;
  logic             load_out;

  assign cfg_ready = 1'b1;
  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign is_full   = (entry_count == CNT_W'(MAX_THREADS));
  assign elapsed   = q_req.now_ticks - resume_time;
  assign consider  = sched_enable && (entry_count >= CNT_W'(2)) &&
                     ((elapsed > {16'd0, time_quantum}) || (max_prio > cur_prio));
  assign load_out  = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign ram_we    = q_pop && (q_req.kind == REQ_ADD) && !is_full;
  assign ram_wdata = '{prio: q_req.thread_priority, id: q_req.thread_id};
  assign ram_rdata = entry_t'(ram_rbits);

  prrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_THREADS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (entry_count[IDX_W-1:0]),
    .wdata (ram_wdata),
    .raddr (walk_index),
    .rdata (ram_rbits)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sched_enable <= 1'b0;
      time_quantum <= DEFAULT_QUANTUM;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SCHED_ENABLE) begin
        sched_enable <= cfg_data[0];
      end else if (cfg_index == CFG_TIME_QUANTUM) begin
        time_quantum <= cfg_data[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      entry_count   <= '0;
      current_index <= '0;
      walk_index    <= '0;
      cur_id        <= '0;
      cur_prio      <= '0;
      max_prio      <= '0;
      resume_time   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            res.pad <= '0;
            if (q_req.kind == REQ_ADD) begin
              res.switched <= 1'b0;
              res.current_valid <= 1'b1;
              if (is_full) begin
                res.table_full <= 1'b1;
                res.current_id <= cur_id;
              end else begin
                res.table_full <= 1'b0;
                entry_count    <= entry_count + CNT_W'(1);
                if (entry_count == '0) begin
                  current_index  <= '0;
                  cur_id         <= q_req.thread_id;
                  cur_prio       <= q_req.thread_priority;
                  max_prio       <= q_req.thread_priority;
                  res.current_id <= q_req.thread_id;
                end else begin
                  res.current_id <= cur_id;
                  if (q_req.thread_priority > max_prio) begin
                    max_prio <= q_req.thread_priority;
                  end
                end
              end
              state <= ST_DONE;
            end else begin
              res.table_full    <= 1'b0;
              res.switched      <= 1'b0;
              res.current_id    <= cur_id;
              res.current_valid <= (entry_count != '0);
              if (consider) begin
                walk_index <= next_idx(current_index, entry_count);
                walk_now   <= q_req.now_ticks;
                state      <= ST_READ;
              end else begin
                state <= ST_DONE;
              end
            end
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (ram_rdata.prio >= cur_prio) begin
            // the walk stops at the current entry at the latest
            if (walk_index != current_index) begin
              current_index  <= walk_index;
              cur_id         <= ram_rdata.id;
              cur_prio       <= ram_rdata.prio;
              resume_time    <= walk_now;
              res.current_id <= ram_rdata.id;
              res.switched   <= 1'b1;
            end
            state <= ST_DONE;
          end else begin
            walk_index <= next_idx(walk_index, entry_count);
            state      <= ST_READ;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= res;
    end
  end

endmodule

[src/priority_round_robin_scheduler.sv]
// flow: an add, or a tick that leaves the schedule alone, goes from the idle state to the done
//   state and, once the output is free, loads m_axis_tdata and raises m_axis_tvalid; a tick that
//   walks the table first visits up to MAX_THREADS entries, each with one table read and one compare
// the back end handles one request at a time
// reset: synchronous active-high rst empties the table, clears the queue and output,
//   disables scheduling and restores the default quantum of 100
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler
// thread table with round-robin selection among threads of at least the
// current priority, switching on quantum expiry or a higher-priority thread
// ----------------------------------------------------------------------------
module priority_round_robin_scheduler (
  input  logic                              clk,
  input  logic                              rst,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] thread_id, [15:8] thread_priority, [47:16] now_ticks
  input  logic [prrs_pkg::S_DATA_W-1:0]     s_axis_tdata,
  // [0] req_type (0 add thread, 1 scheduler tick)
  input  logic [0:0]                        s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] current_id, [8] current_valid, [9] switched, [10] table_full, [15:11] zero
  output logic [prrs_pkg::M_DATA_W-1:0]     m_axis_tdata,
  // register writes: index 0 sched_enable, index 1 time_quantum
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [prrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prrs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import prrs_pkg::*;

  // decoded requests waiting for the back end
  logic q_valid;
  logic q_pop;
  req_t q_req;

  // front end: takes a transaction whenever the two-entry queue has room,
  // so it keeps accepting while a result waits on the output
  prrs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .q_pop         (q_pop)
  );

  // back end: owns the table, the current thread and the output register;
  // one request at a time, the walk reads one table entry and then compares it, entry by entry
  prrs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .q_pop         (q_pop),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[src/prrs_checker.sv]
// ----------------------------------------------------------------------------
// prrs_checker
// port-level checks of the scheduler, bound to the top level
// ----------------------------------------------------------------------------
`include "priority_round_robin_scheduler_macros.svh"

module prrs_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [prrs_pkg::M_DATA_W-1:0]     m_axis_tdata
);
  import prrs_pkg::*;

  // a result with no thread carries id zero
  `PRRS_ASSERT_NOW(a_empty_id_zero, clk, rst, m_axis_tvalid && !m_axis_tdata[8], m_axis_tdata[7:0] == 8'd0)
  // a switch and a refused add never come from the same transaction
  `PRRS_ASSERT_NOW(a_switch_xor_full, clk, rst, m_axis_tvalid, !(m_axis_tdata[9] && m_axis_tdata[10]))
  // a switch needs a thread present
  `PRRS_ASSERT_NOW(a_switch_has_thread, clk, rst, m_axis_tvalid && m_axis_tdata[9], m_axis_tdata[8])
  // no result right after reset
  `PRRS_ASSERT_ALWAYS(a_reset_quiet, clk, rst, !m_axis_tvalid)
  // a stalled result stays offered
  `PRRS_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

endmodule

bind priority_round_robin_scheduler prrs_checker u_prrs_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
